@@ sv/epoch_seconds_to_civil_datetime_macros.svh @@
// Assertion macros for the epoch to civil datetime checker
`ifndef EPOCH_SECONDS_TO_CIVIL_DATETIME_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATETIME_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ECD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ECD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ecd_pkg.sv @@
// Types, constants and tables for the epoch to civil datetime pipeline
`timescale 1ns / 1ps

package ecd_pkg;

  localparam int unsigned STAGES = 8;

  typedef struct packed {
    logic [STAGES-1:0] ld;
  } pipe_ctl_t;

  localparam logic [32:0]        SECS_PER_DAY  = 33'd86400;
  localparam logic signed [17:0] SECS_PER_HOUR = 18'sd3600;

  // seconds / 86400 = (seconds >> 7) / 675
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_DIV   = 675;
  localparam int unsigned DAY_K     = 36;
  localparam logic [26:0] DAY_MUL   =
    27'(((64'd1 << DAY_K) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

  localparam logic [19:0] DAYS_TO_EPOCH_M1 = 20'd719467;
  localparam logic [19:0] ERA4_START       = 20'd584388;
  localparam logic [19:0] ERA5_START       = 20'd730485;
  localparam logic [17:0] ERA_LAST_DAY     = 18'd146096;

  // second of day / 3600 = (sod >> 4) / 225
  localparam int unsigned HOUR_DIV = 225;
  localparam int unsigned HOUR_K   = 21;
  localparam logic [13:0] HOUR_MUL =
    14'(((64'd1 << HOUR_K) + 64'(HOUR_DIV) - 64'd1) / 64'(HOUR_DIV));
  localparam logic [11:0] SECS_PER_HOUR_U = 12'd3600;

  // second of hour / 60 = (rem >> 2) / 15
  localparam int unsigned MIN_DIV = 15;
  localparam int unsigned MIN_K   = 14;
  localparam logic [10:0] MIN_MUL =
    11'(((64'd1 << MIN_K) + 64'(MIN_DIV) - 64'd1) / 64'(MIN_DIV));
  localparam logic [11:0] SECS_PER_MIN = 12'd60;

  // day of era / 1460 = (doe >> 2) / 365
  localparam int unsigned Q4Y_DIV = 365;
  localparam int unsigned Q4Y_K   = 25;
  localparam logic [16:0] Q4Y_MUL =
    17'(((64'd1 << Q4Y_K) + 64'(Q4Y_DIV) - 64'd1) / 64'(Q4Y_DIV));

  // day of era / 36524 = (doe >> 2) / 9131
  localparam int unsigned CENT_DIV = 9131;
  localparam int unsigned CENT_K   = 30;
  localparam logic [16:0] CENT_MUL =
    17'(((64'd1 << CENT_K) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

  // year of era = t / 365
  localparam int unsigned YEAR_DIV = 365;
  localparam int unsigned YEAR_K   = 27;
  localparam logic [18:0] YEAR_MUL =
    19'(((64'd1 << YEAR_K) + 64'(YEAR_DIV) - 64'd1) / 64'(YEAR_DIV));
  localparam logic [17:0] DAYS_PER_YEAR = 18'd365;

  // year of era / 100 = (yoe >> 2) / 25
  localparam int unsigned Y100_DIV = 25;
  localparam int unsigned Y100_K   = 12;
  localparam logic [7:0]  Y100_MUL =
    8'(((64'd1 << Y100_K) + 64'(Y100_DIV) - 64'd1) / 64'(Y100_DIV));

  // March-based month = (5 * doy + 2) / 153
  localparam int unsigned MP_DIV = 153;
  localparam int unsigned MP_K   = 19;
  localparam logic [11:0] MP_MUL =
    12'(((64'd1 << MP_K) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

  localparam logic [3:0]  MP_JANUARY = 4'd10;
  localparam logic [11:0] YEAR_BASE_ERA4 = 12'd1600;
  localparam logic [11:0] YEAR_BASE_ERA5 = 12'd2000;

  // days from March 1 to the first of March-based month mp
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // days from January 1 (common year) to the first of March-based month mp
  function automatic logic [8:0] jan_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd59;
      4'd1:    v = 9'd90;
      4'd2:    v = 9'd120;
      4'd3:    v = 9'd151;
      4'd4:    v = 9'd181;
      4'd5:    v = 9'd212;
      4'd6:    v = 9'd243;
      4'd7:    v = 9'd273;
      4'd8:    v = 9'd304;
      4'd9:    v = 9'd334;
      4'd10:   v = 9'd0;
      4'd11:   v = 9'd31;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/ecd_ctrl.sv @@
// Valid tracking and per-stage load enables for the conversion pipeline
`timescale 1ns / 1ps

module ecd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output ecd_pkg::pipe_ctl_t ctl
);

  localparam int unsigned NS = ecd_pkg::STAGES;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;

  // a stage loads when it is empty or its successor loads; the last stage loads when empty or out_stall is low
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.ld    = adv;
  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NS-1];

endmodule

@@ sv/ecd_day_split.sv @@
// Input register, time-zone shift and split into local day number and second of day
`timescale 1ns / 1ps

module ecd_day_split (
  input  logic               clk,
  input  ecd_pkg::pipe_ctl_t ctl,
  input  logic signed [4:0]  tz,
  input  logic [31:0]        epoch,
  output logic [16:0]        sod,
  output logic [17:0]        doe,
  output logic               era_hi,
  output logic               known
);

  logic [31:0] epoch_r;

  logic signed [17:0] tz_sec;
  logic [32:0]        shifted;
  logic [52:0]        dprod;
  logic [25:0]        x_nxt;
  logic [15:0]        q_nxt;
  logic [25:0]        x1_r;
  logic [6:0]         lo1_r;
  logic [15:0]        q1_r;
  logic               kn1_r;

  logic [25:0] r_full;
  logic [19:0] z;
  logic        era_hi_nxt;
  logic [17:0] doe_nxt;
  logic [16:0] sod_nxt;
  logic [16:0] sod2_r;
  logic [17:0] doe2_r;
  logic        era2_r;
  logic        kn2_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      epoch_r <= epoch;
    end
  end

  // shift by one day so the sum stays positive for any offset
  always_comb begin
    tz_sec  = 18'(tz) * ecd_pkg::SECS_PER_HOUR;
    shifted = 33'(epoch_r) + ecd_pkg::SECS_PER_DAY + 33'(tz_sec);
    x_nxt   = shifted[32:ecd_pkg::DAY_SHIFT];
    dprod   = 53'(x_nxt) * 53'(ecd_pkg::DAY_MUL);
    q_nxt   = dprod[ecd_pkg::DAY_K +: 16];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      x1_r  <= x_nxt;
      lo1_r <= shifted[ecd_pkg::DAY_SHIFT-1:0];
      q1_r  <= q_nxt;
      kn1_r <= (epoch_r != '0);
    end
  end

  always_comb begin
    r_full     = 26'(x1_r - 26'(32'(q1_r) * ecd_pkg::DAY_DIV));
    sod_nxt    = {r_full[9:0], lo1_r};
    z          = 20'(q1_r) + ecd_pkg::DAYS_TO_EPOCH_M1;
    era_hi_nxt = (z >= ecd_pkg::ERA5_START);
    doe_nxt    = 18'(z - (era_hi_nxt ? ecd_pkg::ERA5_START : ecd_pkg::ERA4_START));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      sod2_r <= sod_nxt;
      doe2_r <= doe_nxt;
      era2_r <= era_hi_nxt;
      kn2_r  <= kn1_r;
    end
  end

  assign sod    = sod2_r;
  assign doe    = doe2_r;
  assign era_hi = era2_r;
  assign known  = kn2_r;

endmodule

@@ sv/ecd_tod.sv @@
// Time-of-day stages: second of day to hour, minute and second
`timescale 1ns / 1ps

module ecd_tod (
  input  logic               clk,
  input  ecd_pkg::pipe_ctl_t ctl,
  input  logic [16:0]        sod,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);

  logic [26:0] hprod;
  logic [4:0]  hour_nxt;
  logic [16:0] sod3_r;
  logic [4:0]  hour3_r;

  logic [11:0] rem_nxt;
  logic [4:0]  hour4_r;
  logic [11:0] rem4_r;

  logic [20:0] mprod;
  logic [5:0]  min_nxt;
  logic [4:0]  hour5_r;
  logic [5:0]  min5_r;
  logic [11:0] rem5_r;

  logic [11:0] sec_full;
  logic [4:0]  hour6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;

  always_comb begin
    hprod    = 27'(sod[16:4]) * 27'(ecd_pkg::HOUR_MUL);
    hour_nxt = hprod[ecd_pkg::HOUR_K +: 5];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      sod3_r  <= sod;
      hour3_r <= hour_nxt;
    end
  end

  assign rem_nxt = 12'(sod3_r - 17'(hour3_r) * 17'(ecd_pkg::SECS_PER_HOUR_U));

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      hour4_r <= hour3_r;
      rem4_r  <= rem_nxt;
    end
  end

  always_comb begin
    mprod   = 21'(rem4_r[11:2]) * 21'(ecd_pkg::MIN_MUL);
    min_nxt = mprod[ecd_pkg::MIN_K +: 6];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      hour5_r <= hour4_r;
      min5_r  <= min_nxt;
      rem5_r  <= rem4_r;
    end
  end

  assign sec_full = rem5_r - 12'(12'(min5_r) * ecd_pkg::SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec_full[5:0];
    end
  end

  assign hour   = hour6_r;
  assign minute = min6_r;
  assign second = sec6_r;

endmodule

@@ sv/ecd_date.sv @@
// Calendar stages: day of era to year, month, day and day of year
`timescale 1ns / 1ps

module ecd_date (
  input  logic               clk,
  input  ecd_pkg::pipe_ctl_t ctl,
  input  logic [17:0]        doe,
  input  logic               era_hi,
  input  logic               known_in,
  output logic               known,
  output logic [11:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [8:0]         day_of_year
);

  logic [32:0] aprod;
  logic [32:0] bprod;
  logic [6:0]  a_nxt;
  logic [1:0]  b_nxt;
  logic [17:0] doe3_r;
  logic [6:0]  a3_r;
  logic [1:0]  b3_r;
  logic        c3_r;
  logic        era3_r;
  logic        kn3_r;

  logic [17:0] t_nxt;
  logic [36:0] yprod;
  logic [8:0]  yoe_nxt;
  logic [17:0] doe4_r;
  logic [8:0]  yoe4_r;
  logic        era4_r;
  logic        kn4_r;

  logic [14:0] cprod;
  logic [17:0] ystart;
  logic [17:0] doy_full;
  logic [8:0]  doy5_r;
  logic [8:0]  yoe5_r;
  logic        era5_r;
  logic        kn5_r;

  logic [22:0] pprod;
  logic [3:0]  mp_nxt;
  logic [3:0]  mp6_r;
  logic [8:0]  doy6_r;
  logic [8:0]  yoe6_r;
  logic        era6_r;
  logic        kn6_r;

  logic        jan_feb;
  logic [8:0]  dom0;
  logic [8:0]  yp;
  logic        leap;

  always_comb begin
    aprod = 33'(doe[17:2]) * 33'(ecd_pkg::Q4Y_MUL);
    bprod = 33'(doe[17:2]) * 33'(ecd_pkg::CENT_MUL);
    a_nxt = aprod[ecd_pkg::Q4Y_K +: 7];
    b_nxt = bprod[ecd_pkg::CENT_K +: 2];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      doe3_r <= doe;
      a3_r   <= a_nxt;
      b3_r   <= b_nxt;
      c3_r   <= (doe == ecd_pkg::ERA_LAST_DAY);
      era3_r <= era_hi;
      kn3_r  <= known_in;
    end
  end

  always_comb begin
    t_nxt   = doe3_r - 18'(a3_r) + 18'(b3_r) - 18'(c3_r);
    yprod   = 37'(t_nxt) * 37'(ecd_pkg::YEAR_MUL);
    yoe_nxt = yprod[ecd_pkg::YEAR_K +: 9];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      doe4_r <= doe3_r;
      yoe4_r <= yoe_nxt;
      era4_r <= era3_r;
      kn4_r  <= kn3_r;
    end
  end

  always_comb begin
    cprod    = 15'(yoe4_r[8:2]) * 15'(ecd_pkg::Y100_MUL);
    ystart   = 18'(yoe4_r) * ecd_pkg::DAYS_PER_YEAR + 18'(yoe4_r[8:2])
               - 18'(cprod[ecd_pkg::Y100_K +: 2]);
    doy_full = doe4_r - ystart;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      doy5_r <= doy_full[8:0];
      yoe5_r <= yoe4_r;
      era5_r <= era4_r;
      kn5_r  <= kn4_r;
    end
  end

  always_comb begin
    pprod  = 23'({doy5_r, 2'b00} + 11'(doy5_r) + 11'd2) * 23'(ecd_pkg::MP_MUL);
    mp_nxt = pprod[ecd_pkg::MP_K +: 4];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      mp6_r  <= mp_nxt;
      doy6_r <= doy5_r;
      yoe6_r <= yoe5_r;
      era6_r <= era5_r;
      kn6_r  <= kn5_r;
    end
  end

  // January and February belong to the next year of the era
  always_comb begin
    jan_feb     = (mp6_r >= ecd_pkg::MP_JANUARY);
    dom0        = doy6_r - ecd_pkg::mar_start(mp6_r);
    yp          = yoe6_r + 9'(jan_feb);
    leap        = (yp[1:0] == 2'b00) && (yp != 9'd100) && (yp != 9'd200) && (yp != 9'd300);
    month       = jan_feb ? 4'(mp6_r - 4'd9) : 4'(mp6_r + 4'd3);
    day         = 5'(dom0 + 9'd1);
    year        = 12'(yp) + (era6_r ? ecd_pkg::YEAR_BASE_ERA5 : ecd_pkg::YEAR_BASE_ERA4);
    day_of_year = ecd_pkg::jan_start(mp6_r) + dom0 + 9'(leap && !jan_feb);
    known       = kn6_r;
  end

endmodule

@@ sv/epoch_seconds_to_civil_datetime.sv @@
// Top level: epoch seconds to local civil date and time of day
`timescale 1ns / 1ps
// Throughput: one item per clock; eight stages, at most one constant-reciprocal multiply
//   on any path; in_stall rises only with all eight stages full and out_stall high.
// Reset: rst_n low at a clock edge empties the pipeline and sets the offset to 0.
// A timestamp of zero gives out_time_known = 0 with all other fields zero.

module epoch_seconds_to_civil_datetime (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic signed [4:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_epoch_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_time_known,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic [8:0]        out_day_of_year
);

  localparam int unsigned LAST = ecd_pkg::STAGES - 1;

  ecd_pkg::pipe_ctl_t ctl;

  logic signed [4:0] tz_r;

  logic [16:0] sod;
  logic [17:0] doe;
  logic        era_hi;
  logic        known2;

  logic        known6;
  logic [11:0] year6;
  logic [3:0]  month6;
  logic [4:0]  day6;
  logic [8:0]  yday6;
  logic [4:0]  hour6;
  logic [5:0]  min6;
  logic [5:0]  sec6;

  logic        known_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [8:0]  yday_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= '0;
    end else if (cfg_wr_en) begin
      tz_r <= cfg_wr_data;
    end
  end

  ecd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  ecd_day_split u_day_split (
    .clk    (clk),
    .ctl    (ctl),
    .tz     (tz_r),
    .epoch  (in_epoch_seconds),
    .sod    (sod),
    .doe    (doe),
    .era_hi (era_hi),
    .known  (known2)
  );

  ecd_tod u_tod (
    .clk    (clk),
    .ctl    (ctl),
    .sod    (sod),
    .hour   (hour6),
    .minute (min6),
    .second (sec6)
  );

  ecd_date u_date (
    .clk         (clk),
    .ctl         (ctl),
    .doe         (doe),
    .era_hi      (era_hi),
    .known_in    (known2),
    .known       (known6),
    .year        (year6),
    .month       (month6),
    .day         (day6),
    .day_of_year (yday6)
  );

  // zero every field of an unknown timestamp
  always_ff @(posedge clk) begin
    if (ctl.ld[LAST]) begin
      known_r <= known6;
      year_r  <= known6 ? year6  : '0;
      month_r <= known6 ? month6 : '0;
      day_r   <= known6 ? day6   : '0;
      hour_r  <= known6 ? hour6  : '0;
      min_r   <= known6 ? min6   : '0;
      sec_r   <= known6 ? sec6   : '0;
      yday_r  <= known6 ? yday6  : '0;
    end
  end

  assign out_time_known  = known_r;
  assign out_year        = year_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_hour        = hour_r;
  assign out_minute      = min_r;
  assign out_second      = sec_r;
  assign out_day_of_year = yday_r;

endmodule

@@ sv/ecd_checker.sv @@
// Port-level checker for the epoch to civil datetime block, bound to the top level
`timescale 1ns / 1ps
`include "epoch_seconds_to_civil_datetime_macros.svh"

module ecd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_time_known,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second,
  input logic [8:0]  out_day_of_year
);

  logic [47:0] fields;
  logic        fields_zero;
  logic        fields_ok;

  assign fields = {out_time_known, out_year, out_month, out_day, out_hour,
                   out_minute, out_second, out_day_of_year};

  assign fields_zero = (fields[46:0] == '0);

  assign fields_ok = (out_year >= 12'd1969) && (out_year <= 12'd2106) &&
                     (out_month >= 4'd1) && (out_month <= 4'd12) &&
                     (out_day >= 5'd1) && (out_day <= 5'd31) &&
                     (out_hour <= 5'd23) && (out_minute <= 6'd59) &&
                     (out_second <= 6'd59) && (out_day_of_year <= 9'd365);

  `ECD_ASSERT_SAME(a_unknown_zero, out_valid && !out_time_known, fields_zero, "field not zeroed")
  `ECD_ASSERT_SAME(a_known_range, out_valid && out_time_known, fields_ok, "field out of range")
  `ECD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(fields), "item changed")
  `ECD_ASSERT_SAME(a_stall_full, in_stall, out_valid, "input stalled while no result is held")

endmodule

bind epoch_seconds_to_civil_datetime ecd_checker u_ecd_checker (.*);

@@ dv/epoch_seconds_to_civil_datetime_tb.sv @@
// Self-checking testbench for the epoch seconds to local civil datetime converter
`timescale 1ns / 1ps

module epoch_seconds_to_civil_datetime_tb;

  typedef struct {
    logic        time_known;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [8:0]  day_of_year;
  } civil_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic signed [4:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [31:0]       in_epoch_seconds;
  logic              out_valid;
  logic              out_stall;
  logic              out_time_known;
  logic [11:0]       out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [4:0]        out_hour;
  logic [5:0]        out_minute;
  logic [5:0]        out_second;
  logic [8:0]        out_day_of_year;

  civil_t            expected_dates[$];
  logic signed [4:0] tz_hours;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                hold_left;
  int                mismatches;
  int                items_sent;
  int                results_checked;
  int                tz_settings;

  epoch_seconds_to_civil_datetime DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_time_known   (out_time_known),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_day_of_year  (out_day_of_year)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic civil_t civil_from_epoch(input logic [31:0] ts,
                                              input logic signed [4:0] tz);
    int     jan_offset[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    civil_t r;
    longint local_s, days, sod, z, era, doe, yoe, y, doy, mp, d, m, yday;
    bit     leap;
    r = '{default: '0};
    if (ts == 32'd0) return r;
    local_s = longint'(ts) + 64'sd86400 + longint'(tz) * 64'sd3600;
    days = local_s / 86400;
    sod  = local_s % 86400;
    z    = days - 1 + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y    = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) y = y + 1;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    yday = jan_offset[m - 1] + d - 1;
    if (m > 2 && leap) yday = yday + 1;
    r.time_known  = 1'b1;
    r.year        = 12'(y);
    r.month       = 4'(m);
    r.day         = 5'(d);
    r.hour        = 5'(sod / 3600);
    r.minute      = 6'((sod % 3600) / 60);
    r.second      = 6'(sod % 60);
    r.day_of_year = 9'(yday);
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_result
    civil_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        compare_field("time_known", want.time_known, out_time_known);
        compare_field("year", want.year, out_year);
        compare_field("month", want.month, out_month);
        compare_field("day", want.day, out_day);
        compare_field("hour", want.hour, out_hour);
        compare_field("minute", want.minute, out_minute);
        compare_field("second", want.second, out_second);
        compare_field("day_of_year", want.day_of_year, out_day_of_year);
        results_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_timestamp(input logic [31:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_epoch_seconds = ts;
    do @(posedge clk); while (in_stall);
    expected_dates.push_back(civil_from_epoch(ts, tz_hours));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_dates.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_tz_offset(input logic signed [4:0] hours);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = hours;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tz_hours  = hours;
    tz_settings++;
  endtask

  function automatic logic [31:0] pick_timestamp();
    longint t;
    case ($urandom_range(19)) inside
      0:       return 32'd0;
      [1:2]:   return 32'($urandom_range(200000));
      [3:4]:   return 32'hFFFF_FFFF - 32'($urandom_range(200000));
      [5:10]: begin
        t = longint'($urandom_range(49710)) * 86400 + $urandom_range(7200) - 3600;
        if (t < 0 || t > 64'hFFFF_FFFF) return $urandom;
        return 32'(t);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] utc_edges[13] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd86399, 32'd86400,
                                  32'd946684799, 32'd951782400, 32'd951868800,
                                  32'd1709251199, 32'd4107456000, 32'd4107542400,
                                  32'h8000_0000, 32'h7FFF_FFFF};
    logic [31:0] west_edges[4] = '{32'd1, 32'd57599, 32'd57600, 32'd0};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_tz_offset(5'sd0);
    foreach (utc_edges[i]) send_timestamp(utc_edges[i]);
    set_tz_offset(-5'sd16);
    foreach (west_edges[i]) send_timestamp(west_edges[i]);
    set_tz_offset(5'sd15);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(32'd946629000);
    set_tz_offset(-5'sd12);
    send_timestamp(32'd43199);
    send_timestamp(32'd1234567890);
    set_tz_offset(5'sd14);
    send_timestamp(32'd1);
    send_timestamp(32'd4102393600);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      set_tz_offset(5'($urandom_range(31)));
      repeat (count / 3) send_timestamp(pick_timestamp());
    end
  endtask

  task automatic test_backpressure();
    set_tz_offset(5'($urandom_range(31)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (80) send_timestamp(pick_timestamp());
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    out_stall        = 1'b0;
    tz_hours         = '0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_req         = 1'b0;
    hold_left        = 0;
    mismatches       = 0;
    items_sent       = 0;
    results_checked  = 0;
    tz_settings      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traffic(600, 8, 50);
    test_random_traffic(600, 50, 8);
    test_random_traffic(600, 0, 0);
    test_backpressure();
    wait_idle();

    $display("Converted %0d timestamps, checked %0d datetimes under %0d time-zone settings,",
             items_sent, results_checked, tz_settings);
    $display("with sender gaps, receiver stalls and one long receiver hold-off.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
